>>> rtl/core/svn_pkg.sv
// Shared types and constants for the smooth vertex normal generator.
package svn_pkg;

  localparam int KIND_W = 2;
  localparam int IDX_W = 10;
  localparam int POS_W = 32;
  localparam int NORM_W = 16;
  localparam int ACC_W = 24;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FACE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -24'sh800000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_EDGE,
    S_ESCALE,
    S_CROSS1,
    S_CROSS2,
    S_NSCALE,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_ACC_RD,
    S_ACC_WR,
    S_RACC,
    S_RACC2,
    S_OUT
  } svn_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_pos;
    logic rd_pos;
    logic [1:0] rd_sel;
    logic edge_sub;
    logic edge_scale;
    logic cross1;
    logic cross2;
    logic cross_scale;
    logic square;
    logic sqrt_start;
    logic div_start;
    logic acc_rd;
    logic [1:0] acc_sel;
    logic acc_wr;
    logic racc_rd;
    logic racc_load;
    logic out_load;
  } svn_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic zero_len;
  } svn_sts_t;

endpackage

>>> rtl/core/svn_if.sv
// Valid/ready channel interfaces for the input and result items.
interface svn_in_if;
  logic valid;
  logic ready;
  logic [svn_pkg::KIND_W-1:0] kind;
  logic [svn_pkg::IDX_W-1:0] vertex_index;
  logic signed [svn_pkg::POS_W-1:0] pos_x;
  logic signed [svn_pkg::POS_W-1:0] pos_y;
  logic signed [svn_pkg::POS_W-1:0] pos_z;
  logic [svn_pkg::IDX_W-1:0] corner_a;
  logic [svn_pkg::IDX_W-1:0] corner_b;
  logic [svn_pkg::IDX_W-1:0] corner_c;
  modport source(output valid, kind, vertex_index, pos_x, pos_y, pos_z,
                 corner_a, corner_b, corner_c, input ready);
  modport sink(input valid, kind, vertex_index, pos_x, pos_y, pos_z,
               corner_a, corner_b, corner_c, output ready);
endinterface

interface svn_out_if;
  logic valid;
  logic ready;
  logic [svn_pkg::IDX_W-1:0] vertex_out;
  logic signed [svn_pkg::NORM_W-1:0] norm_x;
  logic signed [svn_pkg::NORM_W-1:0] norm_y;
  logic signed [svn_pkg::NORM_W-1:0] norm_z;
  logic zero_normal;
  modport source(output valid, vertex_out, norm_x, norm_y, norm_z, zero_normal,
                 input ready);
  modport sink(input valid, vertex_out, norm_x, norm_y, norm_z, zero_normal,
               output ready);
endinterface

>>> rtl/core/smooth_vertex_normal_generator.sv
// Top level of the smooth vertex normal generator.
// channel | dir | payload
// in      | in  | kind, vertex_index, pos_x/y/z, corner_a/b/c
// out     | out | vertex_out, norm_x/y/z, zero_normal
// Load: written in the accept cycle. Face: no new item is accepted until it
// ends, paced by the square root and by the divider, which runs once per
// component; a degenerate face skips the divider. Read: may wait for output.
// rst is synchronous; memories hold no reset. A result waits in the output
// register while the next item is accepted; a read that finishes while that
// register is still held stalls in its last state until it is taken.
module smooth_vertex_normal_generator #(
  parameter int VERTICES = 1024
) (
  input logic clk,
  input logic rst,
  svn_in_if.sink   in,
  svn_out_if.source out
);
  localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

  svn_pkg::svn_cmd_t cmd;
  svn_pkg::svn_sts_t sts;
  logic busy, out_set, in_fire, face_ok, rd_ok;
  logic [VW-1:0] ia, ib, ic, ri, acc_idx, rd_idx;
  logic [svn_pkg::IDX_W-1:0] vout;

  assign in.ready = !busy;
  assign in_fire = in.valid && in.ready;

  assign face_ok = (32'(in.corner_a) < 32'(VERTICES)) && (32'(in.corner_b) < 32'(VERTICES))
                   && (32'(in.corner_c) < 32'(VERTICES));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ia <= VW'(in.corner_a);
      ib <= VW'(in.corner_b);
      ic <= VW'(in.corner_c);
      ri <= VW'(in.vertex_index);
      vout <= in.vertex_index;
      rd_ok <= 32'(in.vertex_index) < 32'(VERTICES);
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      2'd0: rd_idx = ia;
      2'd1: rd_idx = ib;
      default: rd_idx = ic;
    endcase
    if (cmd.racc_rd) acc_idx = ri;
    else begin
      unique case (cmd.acc_sel)
        2'd0: acc_idx = ia;
        2'd1: acc_idx = ib;
        default: acc_idx = ic;
      endcase
    end
  end

  svn_ctrl #(.VW(VW)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .kind(in.kind), .face_ok(face_ok),
    .out_free(!out.valid || out.ready), .sts(sts), .cmd(cmd), .busy(busy),
    .out_set(out_set)
  );

  logic load_ok;
  assign load_ok = 32'(in.vertex_index) < 32'(VERTICES);
  svn_pkg::svn_cmd_t dcmd;
  always_comb begin
    dcmd = cmd;
    dcmd.load_pos = cmd.load_pos && load_ok;
  end

  svn_datapath #(.VERTICES(VERTICES), .VW(VW)) u_dp (
    .clk(clk), .rst(rst), .cmd(dcmd), .sts(sts),
    .ld_idx(VW'(in.vertex_index)), .rd_idx(rd_idx), .acc_idx(acc_idx),
    .in_x(in.pos_x), .in_y(in.pos_y), .in_z(in.pos_z), .rd_valid_idx(rd_ok),
    .o_x(out.norm_x), .o_y(out.norm_y), .o_z(out.norm_z), .o_zero(out.zero_normal)
  );

  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (out_set) out.valid <= 1'b1;
    else if (out.ready) out.valid <= 1'b0;
    if (out_set) out.vertex_out <= vout;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_fire) else $error("item accepted while busy");
  a_out_on_set: assert property (@(posedge clk) disable iff (rst)
    out_set |=> out.valid) else $error("result lost");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |-> !out_set) else $error("result overwritten");
endmodule

>>> rtl/core/svn_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module svn_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic [31:0] root,
  output logic        done
);
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= n;
        res <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (bitv == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end
endmodule

>>> rtl/core/svn_div.sv
// Restoring divider shared over three components: round(a*16384/len).
module svn_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [29:0] mag_x,
  input  logic [29:0] mag_y,
  input  logic [29:0] mag_z,
  input  logic [31:0] len,
  output logic [15:0] q_x,
  output logic [15:0] q_y,
  output logic [15:0] q_z,
  output logic        done
);
  // Quotient fits in 16 bits since a <= len; numerator is 45 bits.
  localparam int NUM_W = 45;
  logic [NUM_W-1:0] num;
  logic [32:0]      rem;
  logic [NUM_W-1:0] quo;
  logic [5:0]       cnt;
  logic [1:0]       comp;
  logic             busy;
  logic [33:0]      shifted;
  logic [NUM_W-1:0] numer;

  always_comb begin
    unique case (comp)
      2'd0:    numer = {1'b0, mag_x, 14'd0} + NUM_W'(len >> 1);
      2'd1:    numer = {1'b0, mag_y, 14'd0} + NUM_W'(len >> 1);
      default: numer = {1'b0, mag_z, 14'd0} + NUM_W'(len >> 1);
    endcase
  end

  assign shifted = {rem, num[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      comp <= '0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        comp <= 2'd0;
        cnt <= '0;
        rem <= '0;
        num <= '0;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          num <= numer;
          rem <= '0;
          quo <= '0;
          cnt <= 6'd1;
        end else if (cnt <= 6'(NUM_W)) begin
          if (shifted >= {2'b0, len}) begin
            rem <= 33'(shifted - {2'b0, len});
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            rem <= shifted[32:0];
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          num <= num << 1;
          cnt <= cnt + 6'd1;
        end else begin
          unique case (comp)
            2'd0:    q_x <= quo[15:0];
            2'd1:    q_y <= quo[15:0];
            default: q_z <= quo[15:0];
          endcase
          cnt <= '0;
          if (comp == 2'd2) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            comp <= comp + 2'd1;
          end
        end
      end
    end
  end
endmodule

>>> rtl/core/svn_datapath.sv
// Datapath: position and accumulator memories, edge/cross arithmetic, unitize.
module svn_datapath #(
  parameter int VERTICES = 1024,
  parameter int VW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  svn_pkg::svn_cmd_t   cmd,
  output svn_pkg::svn_sts_t   sts,
  input  logic [VW-1:0]       ld_idx,
  input  logic [VW-1:0]       rd_idx,
  input  logic [VW-1:0]       acc_idx,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic                rd_valid_idx,
  output logic signed [15:0]  o_x,
  output logic signed [15:0]  o_y,
  output logic signed [15:0]  o_z,
  output logic                o_zero
);
  logic [95:0] pos_mem [VERTICES];
  logic [71:0] acc_mem [VERTICES];
  logic [95:0] pos_q;
  logic [71:0] acc_q;

  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic signed [63:0] nv [3];
  logic signed [63:0] p0, p1, p2;
  logic signed [30:0] ns [3];
  logic [63:0] sumsq;
  logic [63:0] sumsq_next;
  logic signed [15:0] q [3];
  logic [15:0] qx, qy, qz;
  logic [31:0] root;
  logic sq_done, dv_done;
  logic load_mem;

  // Position and accumulator memories; registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load_pos) pos_mem[ld_idx] <= {in_x, in_y, in_z};
    if (cmd.rd_pos) pos_q <= pos_mem[rd_idx];
  end

  assign load_mem = cmd.load_pos;

  function automatic logic signed [23:0] sat_add(logic signed [23:0] a,
                                                 logic signed [15:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    if (s > 25'(svn_pkg::ACC_MAX)) return svn_pkg::ACC_MAX;
    else if (s < 25'(svn_pkg::ACC_MIN)) return svn_pkg::ACC_MIN;
    else return s[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (load_mem) acc_mem[ld_idx] <= '0;
    else if (cmd.acc_wr)
      acc_mem[acc_idx] <= {sat_add(acc_q[71:48], q[0]), sat_add(acc_q[47:24], q[1]),
                           sat_add(acc_q[23:0], q[2])};
    if (cmd.acc_rd || cmd.racc_rd) acc_q <= acc_mem[acc_idx];
  end

  // Shift amount so every magnitude sits below 2^lim.
  function automatic logic [5:0] shamt(logic [63:0] m, int lim);
    logic [5:0] s;
    s = '0;
    for (int i = 63; i >= 0; i--) begin
      if (s == '0 && i >= lim && m[i]) s = 6'(i - lim + 1);
    end
    return s;
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  logic [63:0] m1, m2, mn;
  assign m1 = mag64(64'(e1[0])) | mag64(64'(e1[1])) | mag64(64'(e1[2]));
  assign m2 = mag64(64'(e2[0])) | mag64(64'(e2[1])) | mag64(64'(e2[2]));
  assign mn = mag64(nv[0]) | mag64(nv[1]) | mag64(nv[2]);

  // Sum of squares feeds the root directly so it starts in the square cycle.
  assign sumsq_next = $unsigned(64'(ns[0]) * 64'(ns[0]) + 64'(ns[1]) * 64'(ns[1])
                                + 64'(ns[2]) * 64'(ns[2]));

  always_ff @(posedge clk) begin
    if (cmd.rd_pos) begin
      unique case (cmd.rd_sel)
        2'd1: begin
          pa[0] <= pos_q[95:64]; pa[1] <= pos_q[63:32]; pa[2] <= pos_q[31:0];
        end
        2'd2: begin
          pb[0] <= pos_q[95:64]; pb[1] <= pos_q[63:32]; pb[2] <= pos_q[31:0];
        end
        default: ;
      endcase
    end
    if (cmd.edge_sub) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= 33'(pb[i]) - 33'(pa[i]);
      end
      e2[0] <= 33'($signed(pos_q[95:64])) - 33'(pa[0]);
      e2[1] <= 33'($signed(pos_q[63:32])) - 33'(pa[1]);
      e2[2] <= 33'($signed(pos_q[31:0])) - 33'(pa[2]);
    end
    if (cmd.edge_scale) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= e1[i] >>> shamt(m1, 23);
        e2[i] <= e2[i] >>> shamt(m2, 23);
      end
    end
    if (cmd.cross1) begin
      p0 <= 64'(e1[1]) * 64'(e2[2]);
      p1 <= 64'(e1[2]) * 64'(e2[0]);
      p2 <= 64'(e1[0]) * 64'(e2[1]);
    end
    if (cmd.cross2) begin
      nv[0] <= p0 - 64'(e1[2]) * 64'(e2[1]);
      nv[1] <= p1 - 64'(e1[0]) * 64'(e2[2]);
      nv[2] <= p2 - 64'(e1[1]) * 64'(e2[0]);
    end
    if (cmd.cross_scale) begin
      for (int i = 0; i < 3; i++) ns[i] <= 31'(nv[i] >>> shamt(mn, 30));
    end
    if (cmd.racc_load) begin
      ns[0] <= 31'($signed(acc_q[71:48]));
      ns[1] <= 31'($signed(acc_q[47:24]));
      ns[2] <= 31'($signed(acc_q[23:0]));
    end
    if (cmd.square) begin
      sumsq <= sumsq_next;
    end
  end

  function automatic logic [29:0] mag30(logic signed [30:0] v);
    return v[30] ? 30'(-v) : 30'(v);
  endfunction

  svn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sqrt_start), .n(sumsq_next),
    .root(root), .done(sq_done)
  );

  svn_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .mag_x(mag30(ns[0])), .mag_y(mag30(ns[1])), .mag_z(mag30(ns[2])),
    .len(root), .q_x(qx), .q_y(qy), .q_z(qz), .done(dv_done)
  );

  assign q[0] = ns[0][30] ? -$signed(qx) : $signed(qx);
  assign q[1] = ns[1][30] ? -$signed(qy) : $signed(qy);
  assign q[2] = ns[2][30] ? -$signed(qz) : $signed(qz);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sumsq == '0 || !rd_valid_idx) begin
        o_x <= '0; o_y <= '0; o_z <= '0; o_zero <= 1'b1;
      end else begin
        o_x <= q[0]; o_y <= q[1]; o_z <= q[2]; o_zero <= 1'b0;
      end
    end
  end

  assign sts.sqrt_done = sq_done;
  assign sts.div_done = dv_done;
  assign sts.zero_len = (sumsq == '0);
endmodule

>>> rtl/core/svn_ctrl.sv
// Controller: sequences load, face and read items over the datapath.
module svn_ctrl #(
  parameter int VW = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [1:0]        kind,
  input  logic              face_ok,
  input  logic              out_free,
  input  svn_pkg::svn_sts_t sts,
  output svn_pkg::svn_cmd_t cmd,
  output logic              busy,
  output logic              out_set
);
  svn_pkg::svn_state_t state, state_next;
  logic [1:0] corner, corner_next;
  logic face_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svn_pkg::S_IDLE;
      corner <= '0;
    end else begin
      state <= state_next;
      corner <= corner_next;
    end
  end

  always_comb begin
    state_next = state;
    corner_next = corner;
    unique case (state)
      svn_pkg::S_IDLE: begin
        if (in_fire) begin
          if (kind == svn_pkg::KIND_FACE && face_ok) state_next = svn_pkg::S_RD_A;
          else if (kind == svn_pkg::KIND_READ) state_next = svn_pkg::S_RACC;
        end
      end
      svn_pkg::S_RD_A:   state_next = svn_pkg::S_RD_B;
      svn_pkg::S_RD_B:   state_next = svn_pkg::S_RD_C;
      svn_pkg::S_RD_C:   state_next = svn_pkg::S_EDGE;
      svn_pkg::S_EDGE:   state_next = svn_pkg::S_ESCALE;
      svn_pkg::S_ESCALE: state_next = svn_pkg::S_CROSS1;
      svn_pkg::S_CROSS1: state_next = svn_pkg::S_CROSS2;
      svn_pkg::S_CROSS2: state_next = svn_pkg::S_NSCALE;
      svn_pkg::S_NSCALE: state_next = svn_pkg::S_SQ;
      svn_pkg::S_RACC:   state_next = svn_pkg::S_RACC2;
      svn_pkg::S_RACC2:  state_next = svn_pkg::S_SQ;
      svn_pkg::S_SQ:     state_next = svn_pkg::S_SQRT;
      svn_pkg::S_SQRT: begin
        if (sts.zero_len) state_next = svn_pkg::S_OUT;
        else if (sts.sqrt_done) state_next = svn_pkg::S_DIV;
      end
      svn_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_next = svn_pkg::S_OUT;
          corner_next = '0;
        end
      end
      svn_pkg::S_OUT: begin
        // Face items go on to accumulate unless degenerate; read items wait for the output slot.
        if (!face_mode) state_next = out_free ? svn_pkg::S_IDLE : svn_pkg::S_OUT;
        else if (sts.zero_len) state_next = svn_pkg::S_IDLE;
        else state_next = svn_pkg::S_ACC_RD;
      end
      svn_pkg::S_ACC_RD: state_next = svn_pkg::S_ACC_WR;
      svn_pkg::S_ACC_WR: begin
        if (corner == 2'd2) state_next = svn_pkg::S_IDLE;
        else begin
          corner_next = corner + 2'd1;
          state_next = svn_pkg::S_ACC_RD;
        end
      end
      default: state_next = svn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) face_mode <= 1'b0;
    else if (state == svn_pkg::S_IDLE && in_fire) face_mode <= (kind == svn_pkg::KIND_FACE);
  end

  always_comb begin
    cmd = '0;
    out_set = 1'b0;
    cmd.acc_sel = corner;
    unique case (state)
      svn_pkg::S_IDLE:   cmd.load_pos = in_fire && kind == svn_pkg::KIND_LOAD;
      svn_pkg::S_RD_A:   begin cmd.rd_pos = 1'b1; cmd.rd_sel = 2'd0; end
      svn_pkg::S_RD_B:   begin cmd.rd_pos = 1'b1; cmd.rd_sel = 2'd1; end
      svn_pkg::S_RD_C:   begin cmd.rd_pos = 1'b1; cmd.rd_sel = 2'd2; end
      svn_pkg::S_EDGE:   cmd.edge_sub = 1'b1;
      svn_pkg::S_ESCALE: cmd.edge_scale = 1'b1;
      svn_pkg::S_CROSS1: cmd.cross1 = 1'b1;
      svn_pkg::S_CROSS2: cmd.cross2 = 1'b1;
      svn_pkg::S_NSCALE: cmd.cross_scale = 1'b1;
      svn_pkg::S_RACC:   cmd.racc_rd = 1'b1;
      svn_pkg::S_RACC2:  cmd.racc_load = 1'b1;
      svn_pkg::S_SQ:     cmd.square = 1'b1;
      svn_pkg::S_SQRT:   cmd.sqrt_start = 1'b0;
      svn_pkg::S_DIV:    ;
      svn_pkg::S_OUT: begin
        if (!face_mode && out_free) begin
          cmd.out_load = 1'b1;
          out_set = 1'b1;
        end
      end
      svn_pkg::S_ACC_RD: cmd.acc_rd = 1'b1;
      svn_pkg::S_ACC_WR: cmd.acc_wr = 1'b1;
      default: ;
    endcase
    // One-cycle starts: the root in S_SQ, the divider as S_SQRT hands over to S_DIV.
    cmd.sqrt_start = (state == svn_pkg::S_SQ);
    cmd.div_start = (state == svn_pkg::S_SQRT) && sts.sqrt_done && !sts.zero_len;
  end

  assign busy = (state != svn_pkg::S_IDLE);
endmodule
